FILE: src/spt_pkg.sv
// Shared constants and types for the sphere primitive test unit.
package spt_pkg;

	localparam int COORD_BITS = 24;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * MAG_BITS;
	localparam int RSUM_BITS  = COORD_BITS;
	localparam int RSQ_BITS   = 2 * RSUM_BITS;
	localparam int SUM_BITS   = 2 * COORD_BITS + 3;
	localparam int AXES       = 3;

	typedef enum logic [2:0] {
		MODE_POINT     = 3'd0,
		MODE_BOX       = 3'd1,
		MODE_SPHERE    = 3'd2,
		MODE_IN_BOX    = 3'd3,
		MODE_IN_SPHERE = 3'd4
	} mode_t;

	typedef struct packed {
		logic dist_test;
		logic fixed_hit;
	} test_ctl_t;

endpackage

FILE: src/sphere_primitive_test_unit.sv
// Sphere vs point, box or sphere, or sphere inside box or sphere: one hit bit per query.
//
// Channel  Signals                                Width (bits)
// query    query_valid, query_stall, mode,        3, centres and corners 24 signed,
//          center_*, sphere_radius, a_*, b_*,     radii 23 unsigned
//          other_radius
// result   result_valid, result_stall, hit        1
//
// An accepted query passes through the input register, the difference and clamp
// stage, the squaring stage with three 25 by 25 bit multipliers and one 24 by 24 bit
// multiplier, then sum and compare into the result register.
// One query is accepted in every cycle while query_stall is low.
// Reset empties the pipeline; no clearing pass is needed.
// Each stage moves on whenever the stage after it is empty or moving, so bubbles are
// squeezed out and, while a finished result waits, queries are taken until every stage is full.
module sphere_primitive_test_unit import spt_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        query_valid,
	output logic                        query_stall,
	input  logic [2:0]                  mode,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] center_z,
	input  logic [RAD_BITS-1:0]         sphere_radius,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic [RAD_BITS-1:0]         other_radius,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        hit
);

	logic en1, en2, en3, en4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	mode_t                      mode_s1;
	logic signed [COORD_BITS-1:0] c_s1 [AXES];
	logic signed [COORD_BITS-1:0] a_s1 [AXES];
	logic signed [COORD_BITS-1:0] b_s1 [AXES];
	logic [RAD_BITS-1:0]        r_s1;
	logic [RAD_BITS-1:0]        rr_s1;

	logic signed [DIFF_BITS-1:0] diff    [AXES];
	logic [MAG_BITS-1:0]         mag     [AXES];
	logic                        fits_ax [AXES];
	logic                        use_clamp;
	test_ctl_t                   ctl;
	logic [RSUM_BITS-1:0]        rad;

	logic [MAG_BITS-1:0]  mag_s2 [AXES];
	test_ctl_t            ctl_s2;
	logic [RSUM_BITS-1:0] rad_s2;

	logic [PROD_BITS-1:0] prod [AXES];
	logic [RSQ_BITS-1:0]  rsq;

	logic [SQ_BITS-1:0]  sq_s3 [AXES];
	logic [RSQ_BITS-1:0] rsq_s3;
	test_ctl_t           ctl_s3;

	logic [SUM_BITS-1:0] dist_sum;
	logic                hit_next;

	assign en4         = !valid_s4 || !result_stall;
	assign en3         = !valid_s3 || en4;
	assign en2         = !valid_s2 || en3;
	assign en1         = !valid_s1 || en2;
	assign query_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= query_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= mode_t'(mode);
			c_s1[0] <= center_x;
			c_s1[1] <= center_y;
			c_s1[2] <= center_z;
			a_s1[0] <= a_x;
			a_s1[1] <= a_y;
			a_s1[2] <= a_z;
			b_s1[0] <= b_x;
			b_s1[1] <= b_y;
			b_s1[2] <= b_z;
			r_s1    <= sphere_radius;
			rr_s1   <= other_radius;
		end
	end

	assign use_clamp = (mode_s1 == MODE_BOX);

	for (genvar g = 0; g < AXES; g++) begin : g_axis
		logic signed [COORD_BITS-1:0] lo_pt;
		logic signed [COORD_BITS-1:0] pt;
		logic signed [DIFF_BITS-1:0]  c_ext;
		logic signed [DIFF_BITS-1:0]  r_ext;
		logic signed [DIFF_BITS-1:0]  ext_lo;
		logic signed [DIFF_BITS-1:0]  ext_hi;

		assign lo_pt  = (c_s1[g] > a_s1[g]) ? c_s1[g] : a_s1[g];
		assign pt     = use_clamp ? ((lo_pt < b_s1[g]) ? lo_pt : b_s1[g]) : a_s1[g];
		assign c_ext  = signed'({c_s1[g][COORD_BITS-1], c_s1[g]});
		assign r_ext  = signed'({2'b00, r_s1});
		assign diff[g] = c_ext - signed'({pt[COORD_BITS-1], pt});
		assign mag[g]  = diff[g][DIFF_BITS-1] ? MAG_BITS'(-diff[g]) : MAG_BITS'(diff[g]);
		assign ext_lo  = c_ext - r_ext;
		assign ext_hi  = c_ext + r_ext;
		assign fits_ax[g] = (signed'({a_s1[g][COORD_BITS-1], a_s1[g]}) <= ext_lo)
			&& (signed'({b_s1[g][COORD_BITS-1], b_s1[g]}) >= ext_hi);
	end

	always_comb begin
		ctl = '0;
		rad = '0;
		case (mode_s1)
			MODE_POINT, MODE_BOX: begin
				ctl.dist_test = 1'b1;
				rad = {1'b0, r_s1};
			end
			MODE_SPHERE: begin
				ctl.dist_test = 1'b1;
				rad = {1'b0, r_s1} + {1'b0, rr_s1};
			end
			MODE_IN_BOX: begin
				ctl.fixed_hit = fits_ax[0] && fits_ax[1] && fits_ax[2];
			end
			MODE_IN_SPHERE: begin
				if (rr_s1 >= r_s1) begin
					ctl.dist_test = 1'b1;
					rad = {1'b0, rr_s1 - r_s1};
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < AXES; i++) begin
				mag_s2[i] <= mag[i];
			end
			ctl_s2 <= ctl;
			rad_s2 <= rad;
		end
	end

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			prod[i] = mag_s2[i] * mag_s2[i];
		end
		rsq = rad_s2 * rad_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < AXES; i++) begin
				sq_s3[i] <= prod[i][SQ_BITS-1:0];
			end
			rsq_s3 <= rsq;
			ctl_s3 <= ctl_s2;
		end
	end

	assign dist_sum = SUM_BITS'(sq_s3[0]) + SUM_BITS'(sq_s3[1]) + SUM_BITS'(sq_s3[2]);
	assign hit_next = ctl_s3.fixed_hit || (ctl_s3.dist_test && (dist_sum <= SUM_BITS'(rsq_s3)));

	always_ff @(posedge clk) begin
		if (en4) begin
			hit <= hit_next;
		end
	end

	assign result_valid = valid_s4;

	// A stage never claims both a fixed answer and a distance test.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(ctl_s2.dist_test && ctl_s2.fixed_hit))
		else $error("stage two carries both a fixed answer and a distance test");

	// Unused mode codes must leave the pipeline as a certain miss.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2 && (mode_s1 > MODE_IN_SPHERE))
		|=> (!ctl_s2.dist_test && !ctl_s2.fixed_hit))
		else $error("unused mode code did not yield a miss");

	// A transaction in the squaring stage reaches the result register when it may move.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en4) |=> valid_s4)
		else $error("transaction lost between squaring stage and result register");

	// A new result only appears when the squaring stage held a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s4) |-> $past(valid_s3))
		else $error("result appeared without a transaction behind it");

endmodule
